### hdl/matrix_add_sub_mul_engine_defines.svh
// Assertion macros shared by the matrix engine RTL.
`ifndef MATRIX_ADD_SUB_MUL_ENGINE_DEFINES_SVH
`define MATRIX_ADD_SUB_MUL_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define MASM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("masm assertion failed");
// Checked at every edge, reset included.
`define MASM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("masm assertion failed");
`else
`define MASM_ASSERT(name, clk, rst_n, prop)
`define MASM_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

### hdl/masm_pkg.sv
// Shared types and constants of the matrix add/subtract/multiply engine.
package masm_pkg;

  localparam int DIM_W   = 4;   // dimension register width
  localparam int OP_W    = 2;
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 3;   // row/column field width
  localparam int ELEM_W  = 16;  // element field width
  localparam int VALUE_W = 35;  // result field width
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_ROWS_A = 3'd0,
    REG_COLS_A = 3'd1,
    REG_ROWS_B = 3'd2,
    REG_COLS_B = 3'd3,
    REG_OP     = 3'd4
  } reg_e;

  // Sequencer controls for the shared arithmetic unit.
  typedef struct packed {
    logic            term_en;    // capture a*b or a+/-b
    logic            acc_en;     // fold the term into the accumulator
    logic            acc_first;  // first term of a result: restart the sum
    logic [OP_W-1:0] op;
  } mac_ctrl_t;

endpackage

### hdl/masm_if.sv
// Valid/ready channel interfaces for element/compute beats and result beats.
interface masm_in_if;
  logic                            valid;
  logic                            ready;
  logic [masm_pkg::CMD_W-1:0]      command;
  logic [masm_pkg::IDX_W-1:0]      row_index;
  logic [masm_pkg::IDX_W-1:0]      col_index;
  logic signed [masm_pkg::ELEM_W-1:0] element;

  modport source (output valid, command, row_index, col_index, element, input ready);
  modport sink   (input valid, command, row_index, col_index, element, output ready);
endinterface

interface masm_out_if;
  logic                                valid;
  logic                                ready;
  logic [masm_pkg::IDX_W-1:0]          out_row;
  logic [masm_pkg::IDX_W-1:0]          out_col;
  logic signed [masm_pkg::VALUE_W-1:0] out_value;
  logic                                shape_error;
  logic                                last;

  modport source (output valid, out_row, out_col, out_value, shape_error, last,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, shape_error, last,
                  output ready);
endinterface

### hdl/masm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module masm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/masm_mac.sv
// Shared arithmetic unit: one multiply or add/subtract term, then accumulate.
module masm_mac #(
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  masm_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [ELEMENT_WIDTH-1:0]     a_i,
  input  logic signed [ELEMENT_WIDTH-1:0]     b_i,
  output logic signed [masm_pkg::VALUE_W-1:0] acc_o
);

  localparam int VW = masm_pkg::VALUE_W;
  localparam int WW = 2 * ELEMENT_WIDTH + 1;

  logic signed [2*ELEMENT_WIDTH-1:0] prod;
  logic signed [WW-1:0]              ea, eb, full;
  logic signed [VW-1:0]              term_q, acc_q;

  assign prod = a_i * b_i;
  assign ea   = WW'(a_i);
  assign eb   = WW'(b_i);

  always_comb begin
    case (ctrl_i.op)
      masm_pkg::OP_MUL: full = WW'(prod);
      masm_pkg::OP_SUB: full = ea - eb;
      default:          full = ea + eb;
    endcase
  end

  // Sums wrap at the result width.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.term_en) begin
      term_q <= VW'(full);
    end
    if (ctrl_i.acc_en) begin
      acc_q <= (ctrl_i.acc_first ? VW'(0) : acc_q) + term_q;
    end
  end

  assign acc_o = acc_q;

endmodule

### hdl/matrix_add_sub_mul_engine.sv
// Flow: a write beat is stored when taken; a compute beat forms each result with the single
//   shared MAC unit (RAM read, term register, accumulate) once per term, K = cols_a terms
//   for multiply and 1 for add/subtract, then S_EMIT waits for a free output register;
//   no new beat is taken until the last result is emitted; a shape error yields one result.
// Reset: async active low; registers return to 1x1 add, element stores are not cleared
//   and an element must be written before it is used.
`include "matrix_add_sub_mul_engine_defines.svh"

module matrix_add_sub_mul_engine #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  masm_in_if.sink                       in_i,
  masm_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [masm_pkg::APB_AW-1:0]   paddr,
  input  logic [masm_pkg::APB_DW-1:0]   pwdata,
  output logic [masm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;  // loop counter width
  localparam int DW    = masm_pkg::DIM_W;
  localparam int OW    = masm_pkg::OP_W;
  localparam int RW    = masm_pkg::IDX_W;
  localparam int VW    = masm_pkg::VALUE_W;
  localparam int EW    = masm_pkg::ELEM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,   // RAM address presented
    S_TERM,   // read data back: form the term
    S_ACC,    // fold the term into the sum
    S_EMIT    // hand the result to the output register
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, writes complete in the access phase)
  // ---------------------------------------------------------------------------
  logic [DW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [OW-1:0] operation_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DW'(1);
      cols_a_q    <= DW'(1);
      rows_b_q    <= DW'(1);
      cols_b_q    <= DW'(1);
      operation_q <= masm_pkg::OP_ADD;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        masm_pkg::REG_ROWS_A: rows_a_q    <= pwdata[DW-1:0];
        masm_pkg::REG_COLS_A: cols_a_q    <= pwdata[DW-1:0];
        masm_pkg::REG_ROWS_B: rows_b_q    <= pwdata[DW-1:0];
        masm_pkg::REG_COLS_B: cols_b_q    <= pwdata[DW-1:0];
        masm_pkg::REG_OP:     operation_q <= pwdata[OW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      masm_pkg::REG_ROWS_A: prdata = masm_pkg::APB_DW'(rows_a_q);
      masm_pkg::REG_COLS_A: prdata = masm_pkg::APB_DW'(cols_a_q);
      masm_pkg::REG_ROWS_B: prdata = masm_pkg::APB_DW'(rows_b_q);
      masm_pkg::REG_COLS_B: prdata = masm_pkg::APB_DW'(cols_b_q);
      masm_pkg::REG_OP:     prdata = masm_pkg::APB_DW'(operation_q);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input beat decode
  // ---------------------------------------------------------------------------
  state_e state_q;
  logic   in_fire, in_range, wr_a_en, wr_b_en, is_compute, shape_ok;
  logic   dims_ok, is_mul;
  logic [AW-1:0] wr_addr;
  logic [ELEMENT_WIDTH-1:0] elem_w;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_range   = (int'(in_i.row_index) < MAX_DIM) && (int'(in_i.col_index) < MAX_DIM);
  assign wr_a_en    = in_fire && in_range && (in_i.command == masm_pkg::CMD_WR_A);
  assign wr_b_en    = in_fire && in_range && (in_i.command == masm_pkg::CMD_WR_B);
  assign is_compute = (in_i.command == masm_pkg::CMD_COMPUTE);
  assign wr_addr    = AW'(int'(in_i.row_index) * MAX_DIM + int'(in_i.col_index));

  // Low ELEMENT_WIDTH bits of the field; a wider store zero-fills above the field.
  if (ELEMENT_WIDTH <= EW) begin : g_elem_narrow
    assign elem_w = in_i.element[ELEMENT_WIDTH-1:0];
  end else begin : g_elem_wide
    assign elem_w = ELEMENT_WIDTH'(unsigned'(in_i.element));
  end

  // Shape check: every dimension in 1..MAX_DIM, then the per-op rule.
  assign dims_ok = (rows_a_q != '0) && (int'(rows_a_q) <= MAX_DIM) &&
                   (cols_a_q != '0) && (int'(cols_a_q) <= MAX_DIM) &&
                   (rows_b_q != '0) && (int'(rows_b_q) <= MAX_DIM) &&
                   (cols_b_q != '0) && (int'(cols_b_q) <= MAX_DIM);
  assign is_mul  = (operation_q == masm_pkg::OP_MUL);

  always_comb begin
    case (operation_q)
      masm_pkg::OP_ADD,
      masm_pkg::OP_SUB: shape_ok = dims_ok && (rows_a_q == rows_b_q) &&
                                   (cols_a_q == cols_b_q);
      masm_pkg::OP_MUL: shape_ok = dims_ok && (cols_a_q == rows_b_q);
      default:          shape_ok = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Element stores and the shared MAC
  // ---------------------------------------------------------------------------
  logic [IW-1:0] r_q, c_q, m_q;
  logic [DW-1:0] nr_q, nc_q, nk_q;
  logic [OW-1:0] op_q;
  logic          err_q;
  logic [IW-1:0] a_col, b_row;
  logic [AW-1:0] a_addr, b_addr;
  logic signed [ELEMENT_WIDTH-1:0] a_rd, b_rd;
  logic signed [VW-1:0] acc;
  masm_pkg::mac_ctrl_t mac_ctrl;

  // Multiply walks A along a row and B down a column; add/sub reads both at (r, c).
  assign a_col  = (op_q == masm_pkg::OP_MUL) ? m_q : c_q;
  assign b_row  = (op_q == masm_pkg::OP_MUL) ? m_q : r_q;
  assign a_addr = AW'(int'(r_q) * MAX_DIM + int'(a_col));
  assign b_addr = AW'(int'(b_row) * MAX_DIM + int'(c_q));

  masm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk_i     (clk_i),
    .wr_en_i   (wr_a_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (elem_w),
    .rd_addr_i (a_addr),
    .rd_data_o (a_rd)
  );

  masm_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk_i     (clk_i),
    .wr_en_i   (wr_b_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (elem_w),
    .rd_addr_i (b_addr),
    .rd_data_o (b_rd)
  );

  assign mac_ctrl.term_en   = (state_q == S_TERM);
  assign mac_ctrl.acc_en    = (state_q == S_ACC);
  assign mac_ctrl.acc_first = (m_q == '0);
  assign mac_ctrl.op        = op_q;

  masm_mac #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (a_rd),
    .b_i    (b_rd),
    .acc_o  (acc)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_err_q, out_last_q;
  logic [RW-1:0] out_row_q, out_col_q;
  logic signed [VW-1:0] out_value_q;
  logic m_last, c_last, r_last, out_free, emit_fire, emit_last;

  assign m_last    = (DW'(m_q) + DW'(1)) == nk_q;
  assign c_last    = (DW'(c_q) + DW'(1)) == nc_q;
  assign r_last    = (DW'(r_q) + DW'(1)) == nr_q;
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_fire = (state_q == S_EMIT) && out_free;
  assign emit_last = err_q || (c_last && r_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= '0;
      c_q         <= '0;
      m_q         <= '0;
      nr_q        <= '0;
      nc_q        <= '0;
      nk_q        <= '0;
      op_q        <= masm_pkg::OP_ADD;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_err_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      // A beat taken with no new one loaded leaves the register empty.
      if (out_valid_q && out_o.ready && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && is_compute) begin
            r_q   <= '0;
            c_q   <= '0;
            m_q   <= '0;
            nr_q  <= rows_a_q;
            nc_q  <= is_mul ? cols_b_q : cols_a_q;
            nk_q  <= is_mul ? cols_a_q : DW'(1);
            op_q  <= operation_q;
            err_q <= !shape_ok;
            state_q <= shape_ok ? S_READ : S_EMIT;
          end
        end
        S_READ: state_q <= S_TERM;
        S_TERM: state_q <= S_ACC;
        S_ACC: begin
          if (m_last) begin
            state_q <= S_EMIT;
          end else begin
            m_q     <= m_q + IW'(1);
            state_q <= S_READ;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= err_q ? RW'(0) : RW'(r_q);
            out_col_q   <= err_q ? RW'(0) : RW'(c_q);
            out_value_q <= err_q ? VW'(0) : acc;
            out_err_q   <= err_q;
            out_last_q  <= emit_last;
            m_q         <= '0;
            if (emit_last) begin
              state_q <= S_IDLE;
            end else begin
              if (c_last) begin
                c_q <= '0;
                r_q <= r_q + IW'(1);
              end else begin
                c_q <= c_q + IW'(1);
              end
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_row     = out_row_q;
  assign out_o.out_col     = out_col_q;
  assign out_o.out_value   = out_value_q;
  assign out_o.shape_error = out_err_q;
  assign out_o.last        = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MASM_ASSERT(a_err_beat_is_last_and_zero, clk_i, rst_ni,
               (out_valid_q && out_err_q) |-> (out_last_q && out_value_q == '0))
  `MASM_ASSERT(a_store_write_only_idle, clk_i, rst_ni,
               (wr_a_en || wr_b_en) |-> (state_q == S_IDLE))
  `MASM_ASSERT(a_last_beat_returns_idle, clk_i, rst_ni,
               (emit_fire && emit_last) |=> (state_q == S_IDLE))
  `MASM_ASSERT(a_acc_follows_term, clk_i, rst_ni,
               (state_q == S_ACC) |-> ($past(state_q) == S_TERM))
  `MASM_ASSERT_ALWAYS(a_no_beat_in_reset, clk_i, !rst_ni |-> !out_valid_q)

endmodule

### sim/matrix_add_sub_mul_engine_tb.sv
// Self-checking testbench for the matrix add/subtract/multiply engine.
module matrix_add_sub_mul_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 8;
  // Worst-case first-result latency (8-deep multiply) plus some margin.
  localparam int SETTLE_CYCLES = 3 * MAX_DIM + 2 + 8;
  localparam int RANDOM_BEATS = 240;

  // Codes the package leaves out: both are legal field values.
  localparam logic [masm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [masm_pkg::OP_W-1:0]  OP_UNUSED  = 2'd3;

  typedef struct {
    logic [masm_pkg::IDX_W-1:0]          row;
    logic [masm_pkg::IDX_W-1:0]          col;
    logic signed [masm_pkg::VALUE_W-1:0] value;
    logic                                err;
    logic                                last;
  } result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [masm_pkg::APB_AW-1:0] paddr;
  logic [masm_pkg::APB_DW-1:0] pwdata;
  logic [masm_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  masm_in_if  in_if ();
  masm_out_if out_if ();

  matrix_add_sub_mul_engine #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (masm_pkg::ELEM_W)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the configuration, updated as each register write lands.
  logic [masm_pkg::DIM_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [masm_pkg::OP_W-1:0]  op_q;

  // Shadow element stores, written on accepted load beats.
  logic signed [masm_pkg::ELEM_W-1:0] a_store [MAX_DIM*MAX_DIM];
  logic signed [masm_pkg::ELEM_W-1:0] b_store [MAX_DIM*MAX_DIM];

  // Stimulus-side record of which entries hold data; a compute never reads
  // an entry that was never loaded.
  bit a_written [MAX_DIM*MAX_DIM];
  bit b_written [MAX_DIM*MAX_DIM];

  result_t pending_results [$];

  int fail_count;
  int beats_sent;
  int tx_idle_pct;
  int rx_idle_pct;

  function automatic bit dim_in_range(logic [masm_pkg::DIM_W-1:0] d);
    return int'(d) >= 1 && int'(d) <= MAX_DIM;
  endfunction

  // Shape rule: add/sub need equal shapes, multiply needs inner dims to agree.
  // Any dimension out of 1..MAX_DIM, or the unused op code, is an error too.
  function automatic bit shapes_ok();
    bit ok;
    ok = dim_in_range(rows_a_q) && dim_in_range(cols_a_q) &&
         dim_in_range(rows_b_q) && dim_in_range(cols_b_q);
    case (op_q)
      masm_pkg::OP_ADD,
      masm_pkg::OP_SUB: ok = ok && rows_a_q == rows_b_q && cols_a_q == cols_b_q;
      masm_pkg::OP_MUL: ok = ok && cols_a_q == rows_b_q;
      default:          ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Updates the shadow stores on loads; on a compute, queues every result
  // beat in row-major order (or a single error beat).
  function automatic void predict_matrix_results(logic [masm_pkg::CMD_W-1:0] cmd,
      logic [masm_pkg::IDX_W-1:0] row, logic [masm_pkg::IDX_W-1:0] col,
      logic signed [masm_pkg::ELEM_W-1:0] elem);
    result_t res;
    longint  acc;
    int      n_cols;
    int      total;
    int      k;
    if (cmd == masm_pkg::CMD_WR_A) begin
      a_store[{row, col}] = elem;
    end else if (cmd == masm_pkg::CMD_WR_B) begin
      b_store[{row, col}] = elem;
    end else if (cmd == masm_pkg::CMD_COMPUTE) begin
      if (!shapes_ok()) begin
        res.row   = '0;
        res.col   = '0;
        res.value = '0;
        res.err   = 1'b1;
        res.last  = 1'b1;
        pending_results.push_back(res);
      end else begin
        n_cols = (op_q == masm_pkg::OP_MUL) ? int'(cols_b_q) : int'(cols_a_q);
        total  = int'(rows_a_q) * n_cols;
        k      = 0;
        for (int r = 0; r < int'(rows_a_q); r++) begin
          for (int c = 0; c < n_cols; c++) begin
            acc = 0;
            if (op_q == masm_pkg::OP_MUL) begin
              for (int m = 0; m < int'(cols_a_q); m++) begin
                acc += longint'(a_store[r*MAX_DIM+m]) * longint'(b_store[m*MAX_DIM+c]);
              end
            end else if (op_q == masm_pkg::OP_ADD) begin
              acc = longint'(a_store[r*MAX_DIM+c]) + longint'(b_store[r*MAX_DIM+c]);
            end else begin
              acc = longint'(a_store[r*MAX_DIM+c]) - longint'(b_store[r*MAX_DIM+c]);
            end
            k++;
            res.row   = masm_pkg::IDX_W'(r);
            res.col   = masm_pkg::IDX_W'(c);
            res.value = acc[masm_pkg::VALUE_W-1:0];
            res.err   = 1'b0;
            res.last  = (k == total);
            pending_results.push_back(res);
          end
        end
      end
    end
    // Command 3 falls through: no store update, no result.
  endfunction

  function automatic void compare_field(string field, logic signed [63:0] want,
      logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_result_beat();
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t unexpected result beat: expected none actual row %0d col %0d value %0d",
               $time, out_if.out_row, out_if.out_col, out_if.out_value);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("out_row", 64'(want.row), 64'(out_if.out_row));
      compare_field("out_col", 64'(want.col), 64'(out_if.out_col));
      compare_field("out_value", 64'(want.value), 64'(out_if.out_value));
      compare_field("shape_error", 64'(want.err), 64'(out_if.shape_error));
      compare_field("last", 64'(want.last), 64'(out_if.last));
    end
  endtask

  // Input monitor: every accepted beat goes through the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      predict_matrix_results(in_if.command, in_if.row_index, in_if.col_index,
                             in_if.element);
    end
  end

  // Result side: check the beat taken at this edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_result_beat();
    end
    out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic set_idle(int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // One beat on the input channel. valid is only lowered during a gap, so it
  // is never dropped and raised in the same step between back-to-back beats.
  task automatic send_item(logic [masm_pkg::CMD_W-1:0] cmd, logic [masm_pkg::IDX_W-1:0] row,
      logic [masm_pkg::IDX_W-1:0] col, logic [masm_pkg::ELEM_W-1:0] elem);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.row_index <= row;
    in_if.col_index <= col;
    in_if.element   <= elem;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == masm_pkg::CMD_WR_A) begin
      a_written[{row, col}] = 1'b1;
    end else if (cmd == masm_pkg::CMD_WR_B) begin
      b_written[{row, col}] = 1'b1;
    end
    if (cmd != CMD_UNUSED) begin
      beats_sent++;
    end
  endtask

  // Compute beat: row/col/element are don't-care, so they carry random bits.
  task automatic send_compute();
    send_item(masm_pkg::CMD_COMPUTE, masm_pkg::IDX_W'($urandom), masm_pkg::IDX_W'($urandom),
              masm_pkg::ELEM_W'($urandom));
  endtask

  // Stop feeding, let every expected result drain, then give any trailing
  // write beats time to retire before the configuration is touched.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase, then psel is lowered before returning.
  task automatic reg_write(masm_pkg::reg_e idx, logic [masm_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      masm_pkg::REG_ROWS_A: rows_a_q = value[masm_pkg::DIM_W-1:0];
      masm_pkg::REG_COLS_A: cols_a_q = value[masm_pkg::DIM_W-1:0];
      masm_pkg::REG_ROWS_B: rows_b_q = value[masm_pkg::DIM_W-1:0];
      masm_pkg::REG_COLS_B: cols_b_q = value[masm_pkg::DIM_W-1:0];
      masm_pkg::REG_OP:     op_q     = value[masm_pkg::OP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic reg_read(masm_pkg::reg_e idx, output logic [masm_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [masm_pkg::APB_DW-1:0] shadow_reg(masm_pkg::reg_e idx);
    case (idx)
      masm_pkg::REG_ROWS_A: return masm_pkg::APB_DW'(rows_a_q);
      masm_pkg::REG_COLS_A: return masm_pkg::APB_DW'(cols_a_q);
      masm_pkg::REG_ROWS_B: return masm_pkg::APB_DW'(rows_b_q);
      masm_pkg::REG_COLS_B: return masm_pkg::APB_DW'(cols_b_q);
      default:              return masm_pkg::APB_DW'(op_q);
    endcase
  endfunction

  task automatic check_registers();
    logic [masm_pkg::APB_DW-1:0] got;
    masm_pkg::reg_e              idx;
    idx = idx.first();
    do begin
      reg_read(idx, got);
      compare_field($sformatf("register %0d", idx), 64'(shadow_reg(idx)), 64'(got));
      idx = idx.next();
    end while (idx != idx.first());
  endtask

  task automatic set_config(logic [masm_pkg::DIM_W-1:0] ra, logic [masm_pkg::DIM_W-1:0] ca,
      logic [masm_pkg::DIM_W-1:0] rb, logic [masm_pkg::DIM_W-1:0] cb,
      logic [masm_pkg::OP_W-1:0] op);
    wait_idle();
    reg_write(masm_pkg::REG_ROWS_A, masm_pkg::APB_DW'(ra));
    reg_write(masm_pkg::REG_COLS_A, masm_pkg::APB_DW'(ca));
    reg_write(masm_pkg::REG_ROWS_B, masm_pkg::APB_DW'(rb));
    reg_write(masm_pkg::REG_COLS_B, masm_pkg::APB_DW'(cb));
    reg_write(masm_pkg::REG_OP, masm_pkg::APB_DW'(op));
  endtask

  // Full-range elements with the two extremes weighted up.
  function automatic logic [masm_pkg::ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return masm_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small matrices; the full 8 now and then.
  function automatic logic [masm_pkg::DIM_W-1:0] rand_dim();
    if ($urandom_range(0, 9) == 0) begin
      return masm_pkg::DIM_W'(MAX_DIM);
    end
    return masm_pkg::DIM_W'($urandom_range(1, 4));
  endfunction

  // Loads every operand entry the next compute reads that has no data yet,
  // and overwrites about a quarter of the others with fresh values.
  task automatic load_operands();
    if (!shapes_ok()) begin
      return;
    end
    for (int r = 0; r < int'(rows_a_q); r++) begin
      for (int c = 0; c < int'(cols_a_q); c++) begin
        if (!a_written[r*MAX_DIM+c] || $urandom_range(0, 3) == 0) begin
          send_item(masm_pkg::CMD_WR_A, masm_pkg::IDX_W'(r), masm_pkg::IDX_W'(c),
                    rand_element());
        end
      end
    end
    for (int r = 0; r < int'(rows_b_q); r++) begin
      for (int c = 0; c < int'(cols_b_q); c++) begin
        if (!b_written[r*MAX_DIM+c] || $urandom_range(0, 3) == 0) begin
          send_item(masm_pkg::CMD_WR_B, masm_pkg::IDX_W'(r), masm_pkg::IDX_W'(c),
                    rand_element());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers come out of reset as a 1x1 add.
  task automatic test_reset_registers();
    check_registers();
  endtask

  // Runs on the reset configuration. Both element extremes, plus a command 3
  // beat between compute beats that must leave no trace.
  task automatic test_add_extremes();
    send_item(masm_pkg::CMD_WR_A, 3'h0, 3'h0, 16'h8000);
    send_item(masm_pkg::CMD_WR_B, 3'h0, 3'h0, 16'h8000);
    send_compute();
    send_item(masm_pkg::CMD_WR_A, 3'h0, 3'h0, 16'h7fff);
    send_item(masm_pkg::CMD_WR_B, 3'h0, 3'h0, 16'h7fff);
    send_item(CMD_UNUSED, 3'h7, 3'h7, 16'hffff);
    send_compute();
  endtask

  task automatic test_subtract();
    set_config(4'd1, 4'd1, 4'd1, 4'd1, masm_pkg::OP_SUB);
    send_item(masm_pkg::CMD_WR_A, 3'h0, 3'h0, 16'h7fff);
    send_item(masm_pkg::CMD_WR_B, 3'h0, 3'h0, 16'h8000);
    send_compute();
  endtask

  // Dot product of two all-min vectors: largest positive magnitude at depth 4.
  task automatic test_multiply_extremes();
    set_config(4'd1, 4'd4, 4'd4, 4'd1, masm_pkg::OP_MUL);
    check_registers();
    for (int m = 0; m < 4; m++) begin
      send_item(masm_pkg::CMD_WR_A, 3'h0, masm_pkg::IDX_W'(m), 16'h8000);
      send_item(masm_pkg::CMD_WR_B, masm_pkg::IDX_W'(m), 3'h0, 16'h8000);
    end
    send_compute();
  endtask

  // Each kind of bad shape yields one error beat.
  task automatic test_shape_errors();
    set_config(4'd2, 4'd1, 4'd1, 4'd1, masm_pkg::OP_ADD);    // row count differs
    send_compute();
    set_config(4'd1, 4'd2, 4'd3, 4'd1, masm_pkg::OP_MUL);    // inner dimensions differ
    send_compute();
    set_config(4'd0, 4'd1, 4'd0, 4'd1, masm_pkg::OP_SUB);    // zero dimension, shapes equal
    send_compute();
    set_config(4'd9, 4'd1, 4'd9, 4'd1, masm_pkg::OP_ADD);    // just above the max dimension
    send_compute();
    set_config(4'd1, 4'd15, 4'd15, 4'd1, masm_pkg::OP_MUL);  // all-ones dimension
    send_compute();
    set_config(4'd1, 4'd1, 4'd1, 4'd1, OP_UNUSED);
    send_compute();
  endtask

  // Random phases: a configuration (mostly legal), operand loads with random
  // content, a little noise, then one or two compute beats. Idling shifts from
  // a slow receiver, to a slow sender, to full rate.
  task automatic test_random_traffic();
    int                         start;
    int                         progress;
    logic [masm_pkg::DIM_W-1:0] ra, ca, rb, cb;
    logic [masm_pkg::OP_W-1:0]  op;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      progress = beats_sent - start;
      if (progress < RANDOM_BEATS / 3) begin
        set_idle(24, 84);
      end else if (progress < 2 * RANDOM_BEATS / 3) begin
        set_idle(84, 24);
      end else begin
        set_idle(0, 0);
      end

      op = masm_pkg::OP_W'($urandom_range(0, 2));
      ra = rand_dim();
      ca = rand_dim();
      if (op == masm_pkg::OP_MUL) begin
        rb = ca;
        cb = rand_dim();
      end else begin
        rb = ra;
        cb = ca;
      end
      // One phase in ten gets a broken shape.
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       ca = '0;
          1:       rb = masm_pkg::DIM_W'($urandom_range(MAX_DIM + 1, 15));
          2:       op = OP_UNUSED;
          default: rb = masm_pkg::DIM_W'(int'(rb) % MAX_DIM + 1);
        endcase
      end
      set_config(ra, ca, rb, cb, op);
      if ($urandom_range(0, 4) == 0) begin
        check_registers();
      end

      repeat ($urandom_range(1, 2)) begin
        load_operands();
        // Noise: stray loads anywhere in the arrays and ignored command 3 beats.
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0:       send_item(masm_pkg::CMD_WR_A, masm_pkg::IDX_W'($urandom),
                               masm_pkg::IDX_W'($urandom), rand_element());
            1:       send_item(masm_pkg::CMD_WR_B, masm_pkg::IDX_W'($urandom),
                               masm_pkg::IDX_W'($urandom), rand_element());
            default: send_item(CMD_UNUSED, masm_pkg::IDX_W'($urandom),
                               masm_pkg::IDX_W'($urandom), masm_pkg::ELEM_W'($urandom));
          endcase
        end
        send_compute();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.command   <= masm_pkg::CMD_WR_A;
    in_if.row_index <= '0;
    in_if.col_index <= '0;
    in_if.element   <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    fail_count = 0;
    beats_sent = 0;
    set_idle(24, 84);
    // Reset state of the configuration shadow: 1x1 add.
    rows_a_q = 4'd1;
    cols_a_q = 4'd1;
    rows_b_q = 4'd1;
    cols_b_q = 4'd1;
    op_q     = masm_pkg::OP_ADD;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_registers();
    test_add_extremes();
    test_subtract();
    test_multiply_extremes();
    test_shape_errors();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0) begin
      $display("matrix_add_sub_mul_engine_tb passed");
    end else begin
      $display("matrix_add_sub_mul_engine_tb failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("matrix_add_sub_mul_engine_tb failed");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/masm_pkg.sv
hdl/masm_if.sv
hdl/masm_ram.sv
hdl/masm_mac.sv
hdl/matrix_add_sub_mul_engine.sv
sim/matrix_add_sub_mul_engine_tb.sv
